// ===== src/fccsw_pkg.sv =====
// Package for the FAT cluster chain sector walker.
// Holds the command, table-type, result and state codes, the control and status structs
// and the channel widths. It depends on nothing else.
package fccsw_pkg;

    localparam int TABLE_BYTES_DEF = 8192;

    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 13;
    localparam int VALUE_W   = 8;
    localparam int CLUSTER_W = 28;
    localparam int LBA_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int SIC_W     = 7;
    localparam int SPC_W     = 8;
    localparam int OFF_W     = 30;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 40;

    localparam logic [CLUSTER_W-1:0] EOC12 = 28'h0000FF8;
    localparam logic [CLUSTER_W-1:0] EOC16 = 28'h000FFF8;
    localparam logic [CLUSTER_W-1:0] EOC32 = 28'hFFFFFF8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_NEXT  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_FAT12 = 2'd1,
        KIND_FAT16 = 2'd2,
        KIND_FAT32 = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK    = 2'd0,
        RES_END   = 2'd1,
        RES_RANGE = 2'd2
    } res_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KIND  = 2'd0,
        CFG_SPC   = 2'd1,
        CFG_DSTART = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_RANGE,
        S_READ,
        S_EVAL,
        S_MUL,
        S_ADD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic start;
        logic step;
        logic kind_end;
        logic offset_latch;
        logic range_err;
        logic read;
        logic eval;
        logic mul;
        logic add;
        logic zero_lba;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic wrap;
        logic kind_unknown;
        logic range_bad;
        logic last_byte;
        logic out_free;
    } dp_stat_t;

    // Sectors per cluster with zero read as one and anything above 128 read as 128.
    function automatic logic [SPC_W-1:0] spc_clamp(input logic [SPC_W-1:0] spc);
        logic [SPC_W-1:0] r;
        r = spc;
        if (spc == 8'd0) begin
            r = 8'd1;
        end else if (spc > 8'd128) begin
            r = 8'd128;
        end
        return r;
    endfunction

endpackage

// ===== src/fccsw_ctrl.sv =====
// Controller state machine of the FAT cluster chain sector walker.
// Sequences one item at a time through decode, table reads, address arithmetic and output.
// Depends on fccsw_pkg.
module fccsw_ctrl
    import fccsw_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                case (stat.cmd)
                    CMD_START: state_next = S_MUL;
                    CMD_NEXT: begin
                        if (!stat.wrap || stat.kind_unknown) begin
                            state_next = S_MUL;
                        end else begin
                            state_next = S_RANGE;
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_RANGE: begin
                if (stat.range_bad) begin
                    state_next = S_MUL;
                end else begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (stat.last_byte) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:  state_next = S_DONE;
            S_DONE: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            S_DECODE: begin
                case (stat.cmd)
                    CMD_LOAD: begin
                        cmd.load     = 1'b1;
                        cmd.zero_lba = 1'b1;
                    end
                    CMD_START: cmd.start = 1'b1;
                    CMD_NEXT: begin
                        cmd.step = 1'b1;
                        if (stat.wrap && stat.kind_unknown) begin
                            cmd.kind_end = 1'b1;
                        end else if (stat.wrap) begin
                            cmd.offset_latch = 1'b1;
                        end
                    end
                    default: cmd.zero_lba = 1'b1;
                endcase
            end
            S_RANGE: cmd.range_err = stat.range_bad;
            S_READ:  cmd.read = 1'b1;
            S_EVAL:  cmd.eval = 1'b1;
            S_MUL:   cmd.mul = 1'b1;
            S_ADD:   cmd.add = 1'b1;
            S_DONE:  cmd.out_load = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== src/fccsw_datapath.sv =====
// Datapath of the FAT cluster chain sector walker: configuration registers, table store,
// chain state, entry assembly, sector address arithmetic and the output register.
// Depends on fccsw_pkg; driven by fccsw_ctrl.
module fccsw_datapath
    import fccsw_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat
);

    localparam int AW = $clog2(TABLE_BYTES);

    logic [7:0]           mem [TABLE_BYTES];
    logic [7:0]           mem_rdata_reg;

    kind_t                kind_reg;
    logic [SPC_W-1:0]     spc_reg;
    logic [LBA_W-1:0]     dstart_reg;

    logic [CMD_W-1:0]     in_cmd_reg;
    logic [INDEX_W-1:0]   in_index_reg;
    logic [VALUE_W-1:0]   in_value_reg;
    logic [CLUSTER_W-1:0] in_cluster_reg;

    logic [CLUSTER_W-1:0] cluster_reg;
    logic [SIC_W-1:0]     sic_reg;
    logic [OFF_W-1:0]     offset_reg;
    logic [1:0]           rd_cnt_reg;
    logic [23:0]          entry_reg;
    logic [LBA_W-1:0]     prod_reg;
    logic [LBA_W-1:0]     lba_reg;
    res_t                 status_reg;

    logic                 m_valid_reg;
    logic [LBA_W-1:0]     m_lba_reg;
    res_t                 m_status_reg;

    logic [SPC_W-1:0]     spc_eff;
    logic [SPC_W-1:0]     cnt;
    logic                 wrap;
    logic                 index_ok;
    logic [OFF_W-1:0]     sum3;
    logic [OFF_W-1:0]     offset_new;
    logic [31:0]          offset_end;
    logic [AW-1:0]        rd_addr;
    logic [31:0]          entry_cur;
    logic [15:0]          raw16;
    logic [CLUSTER_W-1:0] entry_val;
    logic [CLUSTER_W-1:0] eoc;
    logic                 is_end;
    logic [LBA_W-1:0]     cl_m2;
    logic [LBA_W-1:0]     mul_full;

    assign spc_eff   = spc_clamp(spc_reg);
    assign cnt       = {1'b0, sic_reg} + 8'd1;
    assign wrap      = cnt >= spc_eff;
    assign index_ok  = 32'(in_index_reg) < 32'(TABLE_BYTES);
    assign sum3      = OFF_W'(cluster_reg) + {1'b0, cluster_reg, 1'b0};
    assign offset_end = 32'(offset_reg) + ((kind_reg == KIND_FAT32) ? 32'd4 : 32'd2);
    assign rd_addr   = AW'(offset_reg + OFF_W'(rd_cnt_reg));
    assign entry_cur = {mem_rdata_reg, entry_reg};
    assign raw16     = entry_cur[31:16];
    assign cl_m2     = 32'(cluster_reg) - 32'd2;
    assign mul_full  = cl_m2 * LBA_W'(spc_eff);

    always_comb begin
        case (kind_reg)
            KIND_FAT12: offset_new = sum3 >> 1;
            KIND_FAT16: offset_new = {1'b0, cluster_reg, 1'b0};
            default:    offset_new = {cluster_reg, 2'b00};
        endcase
    end

    always_comb begin
        entry_val = entry_cur[CLUSTER_W-1:0];
        eoc       = EOC32;
        is_end    = 1'b0;
        case (kind_reg)
            KIND_FAT12: begin
                entry_val = cluster_reg[0] ? CLUSTER_W'(raw16[15:4]) : CLUSTER_W'(raw16[11:0]);
                eoc       = EOC12;
                is_end    = entry_val >= eoc;
            end
            KIND_FAT16: begin
                entry_val = CLUSTER_W'(raw16);
                eoc       = EOC16;
                is_end    = entry_val >= eoc;
            end
            KIND_FAT32: begin
                is_end = entry_val >= eoc;
            end
            default: is_end = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && index_ok) begin
            mem[AW'(in_index_reg)] <= in_value_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read) begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg   <= KIND_NONE;
            spc_reg    <= 8'd1;
            dstart_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_KIND:   kind_reg   <= kind_t'(cfg_wdata[1:0]);
                CFG_SPC:    spc_reg    <= cfg_wdata[SPC_W-1:0];
                CFG_DSTART: dstart_reg <= cfg_wdata;
                default:    kind_reg   <= kind_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_cmd_reg     <= s_tdata[1:0];
            in_index_reg   <= s_tdata[14:2];
            in_value_reg   <= s_tdata[22:15];
            in_cluster_reg <= s_tdata[50:23];
        end
        if (cmd.offset_latch) begin
            offset_reg <= offset_new;
        end
        if (cmd.read && (rd_cnt_reg != 2'd0)) begin
            entry_reg <= entry_cur[31:8];
        end
        if (cmd.mul) begin
            prod_reg <= mul_full;
        end
        if (cmd.zero_lba) begin
            lba_reg <= '0;
        end else if (cmd.add) begin
            lba_reg <= dstart_reg + prod_reg + 32'(sic_reg);
        end
        if (cmd.out_load) begin
            m_lba_reg    <= lba_reg;
            m_status_reg <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_reg <= '0;
            sic_reg     <= '0;
            rd_cnt_reg  <= '0;
            status_reg  <= RES_OK;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.capture) begin
                status_reg <= RES_OK;
            end
            if (cmd.load && !index_ok) begin
                status_reg <= RES_RANGE;
            end
            if (cmd.start) begin
                cluster_reg <= in_cluster_reg;
                sic_reg     <= '0;
            end
            if (cmd.step) begin
                sic_reg <= wrap ? '0 : cnt[SIC_W-1:0];
            end
            if (cmd.kind_end) begin
                status_reg <= RES_END;
            end
            if (cmd.offset_latch) begin
                rd_cnt_reg <= '0;
            end else if (cmd.read) begin
                rd_cnt_reg <= rd_cnt_reg + 2'd1;
            end
            if (cmd.range_err) begin
                status_reg <= RES_RANGE;
            end
            if (cmd.eval) begin
                if (is_end) begin
                    status_reg <= RES_END;
                end else begin
                    cluster_reg <= entry_val;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.cmd          = cmd_t'(in_cmd_reg);
    assign stat.wrap         = wrap;
    assign stat.kind_unknown = kind_reg == KIND_NONE;
    assign stat.range_bad    = offset_end > 32'(TABLE_BYTES);
    assign stat.last_byte    = rd_cnt_reg == ((kind_reg == KIND_FAT32) ? 2'd3 : 2'd1);
    assign stat.out_free     = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_status_reg, m_lba_reg};

endmodule

// ===== src/fat_cluster_chain_sector_walk_core.sv =====
// Top level of the FAT cluster chain sector walker.
// Instantiates fccsw_ctrl and fccsw_datapath; depends on fccsw_pkg.
//
// The block keeps a byte image of the allocation table, filled by load commands, and walks
// a cluster chain one sector per next command, returning the sector address and a status
// for every transfer it accepts. Items are handled one at a time. A load or an unknown
// command goes from decode to the output; a start or a next ends in the multiply and add
// states, and a next into another cluster under a known table type checks that its entry
// lies in the store and then reads two bytes of it for FAT12 and FAT16 or four for FAT32.
// The table store has a single read port with registered data, so the entry is fetched
// one byte per cycle, and the sector address is formed by a registered multiply followed
// by an add. The output register holds a finished result while the next item is accepted.
// The table store is not cleared after reset and must be loaded before a walk reads it.
module fat_cluster_chain_sector_walk_core
    import fccsw_pkg::*;
#(
    parameter int TABLE_BYTES = TABLE_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command, byte_index, byte_value, start_cluster
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // sector_lba, status
    output logic [M_DATA_W-1:0]  m_tdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    fccsw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fccsw_datapath #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// ===== src/fccsw_checker.sv =====
// Port checker for the FAT cluster chain sector walker, bound to the top level.
// Depends on fccsw_pkg and fat_cluster_chain_sector_walk_core.
module fccsw_checker
    import fccsw_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_DATA_W-1:0]  s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_DATA_W-1:0]  m_tdata
);

    // No result is offered in the cycle after a reset edge.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled result transfer keeps its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only one item is in work, so an accepted transfer closes the input side.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an item is in work");

    // Status is a defined code and the padding bits stay clear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:32] != 2'b11) && (m_tdata[39:34] == 6'b0))
        else $error("bad status or padding on result");

endmodule

bind fat_cluster_chain_sector_walk_core fccsw_checker u_checker (.*);

// ===== dv/fat_cluster_chain_sector_walk_core_tb.sv =====
// Self-checking testbench for fat_cluster_chain_sector_walk_core.
// Loads allocation tables, walks cluster chains under every table type and several cluster sizes,
// and checks each result against an in-bench walker; depends on fccsw_pkg and the RTL only.
`timescale 1ns / 1ps

module fat_cluster_chain_sector_walk_core_tb;
    import fccsw_pkg::*;

    localparam int TBYTES = TABLE_BYTES_DEF;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct {
        logic [LBA_W-1:0] lba;
        res_t             st;
    } sector_res_t;

    typedef struct {
        logic [S_DATA_W-1:0] word;
        sector_res_t         want;
    } walk_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;

    fat_cluster_chain_sector_walk_core #(
        .TABLE_BYTES(TBYTES)
    ) i_dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // Shadow of the walker state and its settings.
    logic [7:0]           fat_img [TBYTES];
    bit                   img_loaded [TBYTES];
    logic [CLUSTER_W-1:0] cur_clus = '0;
    logic [SIC_W-1:0]     sec_idx = '0;
    kind_t                kind_reg = KIND_NONE;
    logic [SPC_W-1:0]     spc_reg = 8'd1;
    logic [LBA_W-1:0]     dstart_reg = '0;

    walk_item_t  walk_items_q [$];
    sector_res_t lba_due_q [$];
    walk_item_t  drv_item;
    sector_res_t mon_want;
    int          items_sent = 0;
    int          n_err = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    logic        hold_arm = 1'b0;

    function automatic int spc_eff();
        if (spc_reg == 8'd0) begin
            return 1;
        end else if (spc_reg > 8'd128) begin
            return 128;
        end
        return int'(spc_reg);
    endfunction

    function automatic logic [LBA_W-1:0] lba_now();
        logic [31:0] rel;
        logic [31:0] spc;
        rel = {4'd0, cur_clus} - 32'd2;
        spc = spc_eff();
        return dstart_reg + rel * spc + {25'd0, sec_idx};
    endfunction

    function automatic void entry_span(input logic [CLUSTER_W-1:0] cl, output longint off,
                                       output int len, output logic [31:0] eoc);
        off = 0;
        len = 0;
        eoc = '0;
        case (kind_reg)
            KIND_FAT12: begin
                off = (longint'(cl) * 3) >> 1;
                len = 2;
                eoc = {4'd0, EOC12};
            end
            KIND_FAT16: begin
                off = longint'(cl) * 2;
                len = 2;
                eoc = {4'd0, EOC16};
            end
            KIND_FAT32: begin
                off = longint'(cl) * 4;
                len = 4;
                eoc = {4'd0, EOC32};
            end
            default: ;
        endcase
    endfunction

    function automatic int clus_top();
        case (kind_reg)
            KIND_FAT12: return 5460;
            KIND_FAT16: return 4095;
            KIND_FAT32: return 2047;
            default: return 28'hFFFFFFF;
        endcase
    endfunction

    function automatic logic [CLUSTER_W-1:0] pick_cluster();
        if ($urandom_range(3) == 0) begin
            return $urandom_range(15);
        end
        return $urandom_range(clus_top());
    endfunction

    // Value for the last link: mostly an end mark, sometimes a cluster whose entry lies
    // outside the table.
    function automatic logic [31:0] chain_tail();
        logic [3:0] top;
        top = $urandom_range(15);
        case (kind_reg)
            KIND_FAT12: begin
                if ($urandom_range(4) == 0) return $urandom_range(5461, 12'hFF7);
                return $urandom_range(12'hFF8, 12'hFFF);
            end
            KIND_FAT16: begin
                if ($urandom_range(4) == 0) return $urandom_range(4096, 16'hFFF7);
                return $urandom_range(16'hFFF8, 16'hFFFF);
            end
            default: begin
                if ($urandom_range(4) == 0) return {top, 28'($urandom_range(2048, 28'hFFFFFF7))};
                return {top, 28'hFFFFFF8 + 28'($urandom_range(7))};
            end
        endcase
    endfunction

    task automatic advance_walker(input cmd_t c, input logic [INDEX_W-1:0] idx,
                                  input logic [VALUE_W-1:0] val,
                                  input logic [CLUSTER_W-1:0] cl, output sector_res_t r);
        longint      off;
        int          len;
        logic [31:0] eoc;
        logic [31:0] ent;
        logic [15:0] w16;
        r.lba = '0;
        r.st = RES_OK;
        case (c)
            CMD_LOAD: begin
                if (int'(idx) < TBYTES) begin
                    fat_img[idx] = val;
                    img_loaded[idx] = 1'b1;
                end else begin
                    r.st = RES_RANGE;
                end
            end
            CMD_START: begin
                cur_clus = cl;
                sec_idx = '0;
                r.lba = lba_now();
            end
            CMD_NEXT: begin
                if (int'(sec_idx) + 1 >= spc_eff()) begin
                    sec_idx = '0;
                    entry_span(cur_clus, off, len, eoc);
                    if (kind_reg == KIND_NONE) begin
                        r.st = RES_END;
                    end else if (off + len > TBYTES) begin
                        r.st = RES_RANGE;
                    end else begin
                        w16 = {fat_img[off+1], fat_img[off]};
                        if (kind_reg == KIND_FAT12) begin
                            ent = cur_clus[0] ? {20'd0, w16[15:4]} : {20'd0, w16[11:0]};
                        end else if (kind_reg == KIND_FAT16) begin
                            ent = {16'd0, w16};
                        end else begin
                            ent = {4'd0, fat_img[off+3][3:0], fat_img[off+2], w16};
                        end
                        if (ent >= eoc) begin
                            r.st = RES_END;
                        end else begin
                            cur_clus = ent[CLUSTER_W-1:0];
                        end
                    end
                end else begin
                    sec_idx = sec_idx + 1'b1;
                end
                r.lba = lba_now();
            end
            default: ;
        endcase
    endtask

    // Fields a command does not use are filled with random bits.
    task automatic send(input cmd_t c, input logic [INDEX_W-1:0] idx,
                        input logic [VALUE_W-1:0] val, input logic [CLUSTER_W-1:0] cl);
        walk_item_t           it;
        sector_res_t          w;
        logic [INDEX_W-1:0]   f_idx;
        logic [VALUE_W-1:0]   f_val;
        logic [CLUSTER_W-1:0] f_cl;
        f_idx = $urandom;
        f_val = $urandom;
        f_cl = $urandom;
        if (c == CMD_LOAD) begin
            f_idx = idx;
            f_val = val;
        end
        if (c == CMD_START) begin
            f_cl = cl;
        end
        it.word = {5'd0, f_cl, f_val, f_idx, c};
        advance_walker(c, f_idx, f_val, f_cl, w);
        it.want = w;
        walk_items_q.push_back(it);
        items_sent++;
    endtask

    task automatic set_entry(input logic [CLUSTER_W-1:0] cl, input logic [31:0] v);
        longint      off;
        int          len;
        logic [31:0] eoc;
        logic [15:0] w16;
        entry_span(cl, off, len, eoc);
        case (kind_reg)
            KIND_FAT12: begin
                w16 = {fat_img[off+1], fat_img[off]};
                w16 = cl[0] ? {v[11:0], w16[3:0]} : {w16[15:12], v[11:0]};
                send(CMD_LOAD, off, w16[7:0], '0);
                send(CMD_LOAD, off + 1, w16[15:8], '0);
            end
            KIND_FAT16: begin
                send(CMD_LOAD, off, v[7:0], '0);
                send(CMD_LOAD, off + 1, v[15:8], '0);
            end
            KIND_FAT32: begin
                for (int i = 0; i < 4; i++) begin
                    send(CMD_LOAD, off + i, v[8*i +: 8], '0);
                end
            end
            default: ;
        endcase
    endtask

    // A next step that crosses a cluster boundary must find its table entry loaded.
    task automatic step_next();
        longint      off;
        int          len;
        logic [31:0] eoc;
        if (kind_reg != KIND_NONE && int'(sec_idx) + 1 >= spc_eff()) begin
            entry_span(cur_clus, off, len, eoc);
            if (off + len <= TBYTES) begin
                for (int i = 0; i < len; i++) begin
                    if (!img_loaded[off+i]) begin
                        send(CMD_LOAD, off + i, $urandom_range(255), '0);
                    end
                end
            end
        end
        send(CMD_NEXT, '0, '0, '0);
    endtask

    task automatic walk_chain(input int n);
        logic [CLUSTER_W-1:0] links [$];
        logic [3:0]           top;
        int                   steps;
        for (int i = 0; i < n; i++) begin
            links.push_back(pick_cluster());
        end
        if (kind_reg != KIND_NONE) begin
            for (int i = 0; i < n; i++) begin
                top = $urandom_range(15);
                set_entry(links[i], (i < n - 1) ? {top, links[i+1]} : chain_tail());
            end
        end
        send(CMD_START, '0, '0, links[0]);
        steps = n * spc_eff() + $urandom_range(2);
        if (steps > 40) begin
            steps = ($urandom_range(7) == 0) ? 140 : $urandom_range(1, 40);
        end
        repeat (steps) begin
            step_next();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_KIND: kind_reg = kind_t'(val[1:0]);
            CFG_SPC: spc_reg = val[SPC_W-1:0];
            CFG_DSTART: dstart_reg = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (!(walk_items_q.size() == 0 && !s_tvalid && lba_due_q.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                lba_due_q.push_back(drv_item.want);
            end
            if (!s_tvalid || s_tready) begin
                if (walk_items_q.size() > 0 && $urandom_range(99) >= send_gap) begin
                    drv_item = walk_items_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= drv_item.word;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_arm) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge aclk) begin
        m_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (lba_due_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none, got %h", $time, m_tdata);
                n_err++;
            end else begin
                mon_want = lba_due_q.pop_front();
                if (m_tdata[31:0] !== mon_want.lba) begin
                    $display("%0t: sector_lba mismatch, expected %h, got %h", $time,
                             mon_want.lba, m_tdata[31:0]);
                    n_err++;
                end
                if (m_tdata[33:32] !== mon_want.st) begin
                    $display("%0t: status mismatch, expected %0d, got %0d", $time,
                             mon_want.st, m_tdata[33:32]);
                    n_err++;
                end
            end
        end
    end

    initial begin
        int target;
        for (int i = 0; i < TBYTES; i++) begin
            fat_img[i] = '0;
            img_loaded[i] = 1'b0;
        end
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Unknown table type: every boundary ends the chain; address below cluster two wraps.
        send(CMD_NONE, '0, '0, '0);
        send(CMD_START, '0, '0, '0);
        send(CMD_NEXT, '0, '0, '0);
        send(CMD_LOAD, '0, 8'hFF, '0);
        send(CMD_LOAD, 13'h1FFF, 8'h00, '0);
        drain();
        write_reg(CFG_SPARE, '1);
        write_reg(CFG_KIND, KIND_FAT12);
        write_reg(CFG_SPC, 8'd2);
        write_reg(CFG_DSTART, '1);

        // FAT12 entries sharing a byte, an end mark and the last entry past the store.
        set_entry(28'd2, 32'd3);
        set_entry(28'd3, 32'hFF8);
        send(CMD_START, '0, '0, 28'd2);
        repeat (4) step_next();
        send(CMD_START, '0, '0, 28'd5461);
        repeat (2) step_next();
        drain();
        write_reg(CFG_KIND, KIND_FAT32);
        write_reg(CFG_SPC, 8'd1);

        // FAT32 top nibble is ignored; the last entry in the store and the first past it.
        set_entry(28'd2047, 32'hF0000005);
        send(CMD_START, '0, '0, 28'd2047);
        step_next();
        send(CMD_START, '0, '0, 28'd2048);
        step_next();
        drain();
        write_reg(CFG_KIND, KIND_FAT16);

        set_entry(28'd4095, 32'h0000FFF7);
        send(CMD_START, '0, '0, 28'd4095);
        repeat (2) step_next();

        for (int p = 0; p < 8; p++) begin
            drain();
            write_reg(CFG_KIND, kind_t'((p + 1) % 4));
            case (p)
                0: write_reg(CFG_SPC, 32'd1);
                1: write_reg(CFG_SPC, 32'd2);
                2: write_reg(CFG_SPC, 32'd0);
                3: write_reg(CFG_SPC, 32'd3);
                4: write_reg(CFG_SPC, 32'd128);
                5: write_reg(CFG_SPC, 32'd255);
                6: write_reg(CFG_SPC, 32'd4);
                default: write_reg(CFG_SPC, $urandom_range(1, 8));
            endcase
            if (p == 0) begin
                write_reg(CFG_DSTART, '0);
            end else if (p == 1) begin
                write_reg(CFG_DSTART, '1);
            end else begin
                write_reg(CFG_DSTART, $urandom);
            end
            case (p % 4)
                0: begin
                    send_gap <= 0;
                    recv_gap <= 0;
                end
                1: begin
                    send_gap <= 68;
                    recv_gap <= 0;
                end
                2: begin
                    send_gap <= 0;
                    recv_gap <= 68;
                end
                default: begin
                    send_gap <= 9;
                    recv_gap <= 9;
                end
            endcase
            target = items_sent + 66;
            while (items_sent < target) begin
                case ($urandom_range(99)) inside
                    [0:64]: walk_chain($urandom_range(1, 5));
                    [65:77]: begin
                        send(CMD_START, '0, '0, $urandom);
                        repeat ($urandom_range(1, 4)) step_next();
                    end
                    [78:87]: send(CMD_LOAD, $urandom, $urandom, '0);
                    [88:93]: step_next();
                    default: send(CMD_NONE, '0, '0, '0);
                endcase
            end
            if (p == 4) begin
                @(posedge aclk);
                hold_arm <= 1'b1;
                @(posedge aclk);
                hold_arm <= 1'b0;
            end
        end
        drain();

        if (n_err == 0) begin
            $display("fat_cluster_chain_sector_walk_core test passed");
        end else begin
            $display("fat_cluster_chain_sector_walk_core test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("fat_cluster_chain_sector_walk_core test failed");
        $finish;
    end

endmodule
